// ===== rtl/rbct_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbct_pkg
// Shared types and constants for the ROM block cache translator.
// ----------------------------------------------------------------------------
package rbct_pkg;

	localparam int unsigned ADDR_BITS   = 25;
	localparam int unsigned CNT_BITS    = 11;
	localparam int unsigned SLOT_COUNT  = 128;
	localparam int unsigned OFFSET_BITS = 15;
	localparam int unsigned MAP_ENTRIES = 1024;
	localparam int unsigned BLOCK_COUNT_RESET = 1024;

	typedef struct packed {
		logic clear;
		logic lookup;
		logic scan_start;
		logic scan_step;
		logic evict;
		logic unmap;
		logic commit;
		logic emit;
	} rbct_cmd_t;

	typedef struct packed {
		logic is_hit;
		logic is_oor;
		logic scan_done;
		logic clear_last;
	} rbct_sts_t;

endpackage

// ===== rtl/rbct_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbct_ctrl
// Sequencer: map clear, lookup, victim scan, eviction, commit and result beat.
// ----------------------------------------------------------------------------
module rbct_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	output rbct_pkg::rbct_cmd_t cmd,
	input  rbct_pkg::rbct_sts_t sts
);
	import rbct_pkg::*;

	typedef enum logic [7:0] {
		ST_CLEAR  = 8'b00000001,
		ST_IDLE   = 8'b00000010,
		ST_LOOKUP = 8'b00000100,
		ST_SCAN   = 8'b00001000,
		ST_EVICT  = 8'b00010000,
		ST_UNMAP  = 8'b00100000,
		ST_COMMIT = 8'b01000000,
		ST_EMIT   = 8'b10000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clear_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (start) begin
					cmd.lookup = 1'b1;
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.is_hit || sts.is_oor) begin
					state_d = ST_EMIT;
				end else begin
					cmd.scan_start = 1'b1;
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_done) state_d = ST_EVICT;
			end
			ST_EVICT: begin
				cmd.evict = 1'b1;
				state_d = ST_UNMAP;
			end
			ST_UNMAP: begin
				cmd.unmap = 1'b1;
				state_d = ST_COMMIT;
			end
			ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.emit = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== rtl/rbct_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbct_datapath
// Block map memory, slot tables, victim scan and result registers.
// ----------------------------------------------------------------------------
module rbct_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [31:0]      address,
	input  logic [rbct_pkg::CNT_BITS-1:0] block_count,
	input  rbct_pkg::rbct_cmd_t cmd,
	output rbct_pkg::rbct_sts_t sts,
	output logic             done,
	output logic [6:0]       slot,
	output logic [14:0]      byte_offset,
	output logic             hit,
	output logic             fill_needed,
	output logic [9:0]       block_number,
	output logic             evicted_valid,
	output logic [9:0]       evicted_block,
	output logic             out_of_range
);
	import rbct_pkg::*;

	localparam int unsigned SB = $clog2(SLOT_COUNT);
	localparam int unsigned MB = $clog2(MAP_ENTRIES);
	localparam int unsigned BB = ADDR_BITS - OFFSET_BITS;
	localparam int unsigned SCB = SB + 1;
	localparam int unsigned CB = (BB > CNT_BITS) ? BB + 1 : CNT_BITS + 1;

	// Each map entry holds a mapped bit and a slot; a clearing pass after reset empties them.
	logic [SB:0]    map_mem [MAP_ENTRIES];
	logic [SB:0]    map_rd_q;
	logic           map_we;
	logic [MB-1:0]  map_wa;
	logic [SB:0]    map_wd;
	logic [MB-1:0]  clr_q;

	// Slots are loaded in the order 1 to SLOT_COUNT-1, then 0, so a count tells which are empty.
	logic [BB-1:0]  owner_mem [SLOT_COUNT];
	logic [BB-1:0]  owner_rd_q;
	logic [31:0]    stamp_mem [SLOT_COUNT];
	logic [31:0]    stamp_rd_q;
	logic [31:0]    load_cnt_q;
	logic [SCB-1:0] fill_cnt_q;

	logic [BB-1:0]          blk_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic                   inmap_q;
	logic                   inidx_q;
	logic [SCB-1:0]         sidx_q;
	logic [SB-1:0]          cidx_q;
	logic                   cv_q;
	logic [SB-1:0]          vic_q;
	logic [31:0]            least_q;
	logic                   full_q;
	logic                   fill_q;
	logic                   map_hit;

	logic [ADDR_BITS-1:0] a_m;
	logic [BB-1:0]        blk_in;
	logic [MB-1:0]        blk_ix;

	assign a_m     = address[ADDR_BITS-1:0];
	assign blk_in  = a_m[ADDR_BITS-1:OFFSET_BITS];
	assign blk_ix  = MB'(blk_in);
	assign map_hit = inidx_q && map_rd_q[SB];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) clr_q <= '0;
		else if (cmd.clear) clr_q <= clr_q + MB'(1);
	end

	always_comb begin
		map_we = 1'b0;
		map_wa = clr_q;
		map_wd = '0;
		if (cmd.clear) begin
			map_we = 1'b1;
		end else if (cmd.unmap) begin
			map_we = full_q && (CB'(owner_rd_q) < CB'(MAP_ENTRIES));
			map_wa = MB'(owner_rd_q);
		end else if (cmd.commit) begin
			map_we = 1'b1;
			map_wa = MB'(blk_q);
			map_wd = {1'b1, vic_q};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) map_rd_q <= map_mem[blk_ix];
		if (map_we) map_mem[map_wa] <= map_wd;
	end

	always_ff @(posedge clk) begin
		if (cmd.evict && full_q) owner_rd_q <= owner_mem[vic_q];
		if (cmd.commit) owner_mem[vic_q] <= blk_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && (sidx_q < SCB'(SLOT_COUNT))) begin
			stamp_rd_q <= stamp_mem[sidx_q[SB-1:0]];
		end
		if (cmd.commit) stamp_mem[vic_q] <= load_cnt_q + 32'd1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			fill_cnt_q <= '0;
			fill_q     <= 1'b0;
		end else begin
			if (cmd.lookup) fill_q <= 1'b0;
			else if (cmd.commit) fill_q <= 1'b1;
			if (cmd.commit) begin
				load_cnt_q <= load_cnt_q + 32'd1;
				if (!full_q) fill_cnt_q <= fill_cnt_q + SCB'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.lookup) begin
			blk_q   <= blk_in;
			off_q   <= a_m[OFFSET_BITS-1:0];
			inidx_q <= (CB'(blk_in) < CB'(MAP_ENTRIES));
			inmap_q <= (CB'(blk_in) < CB'(MAP_ENTRIES)) && (CB'(blk_in) < CB'(block_count));
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			cv_q <= 1'b0;
			if (fill_cnt_q == SCB'(SLOT_COUNT)) begin
				full_q <= 1'b1;
				sidx_q <= '0;
			end else begin
				full_q <= 1'b0;
				sidx_q <= SCB'(SLOT_COUNT);
				vic_q  <= (fill_cnt_q == SCB'(SLOT_COUNT - 1)) ? '0
					: SB'(fill_cnt_q + SCB'(1));
			end
		end else if (cmd.scan_step) begin
			if (sidx_q < SCB'(SLOT_COUNT)) begin
				cidx_q <= sidx_q[SB-1:0];
				cv_q   <= 1'b1;
				sidx_q <= sidx_q + SCB'(1);
			end else begin
				cv_q <= 1'b0;
			end
			if (cv_q) begin
				if (cidx_q == '0) begin
					least_q <= stamp_rd_q;
					vic_q   <= '0;
				end else if (stamp_rd_q < least_q) begin
					least_q <= stamp_rd_q;
					vic_q   <= cidx_q;
				end
			end
		end
	end

	assign sts.is_hit     = map_hit;
	assign sts.is_oor     = !map_hit && !inmap_q;
	assign sts.scan_done  = (sidx_q >= SCB'(SLOT_COUNT)) && !cv_q;
	assign sts.clear_last = (clr_q == MB'(MAP_ENTRIES - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= cmd.emit;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			slot          <= fill_q ? 7'(vic_q) : (map_hit ? 7'(map_rd_q[SB-1:0]) : 7'd0);
			byte_offset   <= 15'(off_q);
			hit           <= map_hit;
			fill_needed   <= fill_q;
			block_number  <= 10'(blk_q);
			evicted_valid <= fill_q & full_q;
			evicted_block <= (fill_q && full_q) ? 10'(owner_rd_q) : 10'd0;
			out_of_range  <= !map_hit && !fill_q;
		end
	end

endmodule

// ===== rtl/rom_block_cache_translator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rom_block_cache_translator
// Fully associative ROM block cache with oldest-loaded replacement.
// ----------------------------------------------------------------------------
// A hit or out-of-range item passes LOOKUP and EMIT; done is registered from EMIT.
// A miss while a slot is still empty passes LOOKUP, SCAN, EVICT, UNMAP, COMMIT and EMIT.
// A miss with all slots loaded also reads the stamps of all SLOT_COUNT slots in SCAN.
// After reset busy stays high while all MAP_ENTRIES (1024) map entries are cleared.
// Reset empties all slots and sets block_count to 1024; the receiver cannot stall.
module rom_block_cache_translator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [31:0] address,
	input  logic        cfg_we,
	input  logic [10:0] cfg_wdata,
	output logic        done,
	output logic [6:0]  slot,
	output logic [14:0] byte_offset,
	output logic        hit,
	output logic        fill_needed,
	output logic [9:0]  block_number,
	output logic        evicted_valid,
	output logic [9:0]  evicted_block,
	output logic        out_of_range
);
	import rbct_pkg::*;

	rbct_cmd_t cmd;
	rbct_sts_t sts;
	logic [CNT_BITS-1:0] block_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) block_count_q <= CNT_BITS'(BLOCK_COUNT_RESET);
		else if (cfg_we) block_count_q <= cfg_wdata;
	end

	rbct_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .sts(sts)
	);

	rbct_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .address(address), .block_count(block_count_q),
		.cmd(cmd), .sts(sts), .done(done), .slot(slot), .byte_offset(byte_offset),
		.hit(hit), .fill_needed(fill_needed), .block_number(block_number),
		.evicted_valid(evicted_valid), .evicted_block(evicted_block),
		.out_of_range(out_of_range)
	);

endmodule
